### design/assert_macros.svh
// assertion helpers shared by the rotation matrix design
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/rrm_pkg.sv
// shared types, constants and rounding helper for the rotation matrix pipeline
// no dependencies
package rrm_pkg;

    // internal fixed point is Q.30
    localparam int unsigned QB = 30;
    localparam logic [30:0] ONE_Q = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
    localparam logic [61:0] RND_Q = 62'h2000_0000;

    typedef logic signed [33:0] t_q;
    typedef logic signed [67:0] t_prod;

    localparam int unsigned N_SIN = 6;
    localparam int unsigned N_COS = 7;
    localparam int unsigned SIN_DIV [N_SIN] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [N_COS] = '{182, 132, 90, 56, 30, 12, 2};

    // pipeline depths
    localparam int unsigned STEP_LAT = 5;
    localparam int unsigned SC_LAT = 4 + N_COS * STEP_LAT + 1;
    localparam int unsigned SQ_LAT = 31;
    localparam int unsigned P_LAT = SC_LAT + 9;

    // signed Q.30 product back to Q.30, half away from zero
    function automatic t_q f_rnd_q30(input t_prod p);
        t_prod adj;
        t_prod s;
        adj = p[67] ? (t_prod'(RND_Q) - t_prod'(1)) : t_prod'(RND_Q);
        s = p + adj;
        return t_q'(s[63:30]);
    endfunction

endpackage

### design/rrm_delay.sv
// enable-gated shift register used to align pipeline operands
// no dependencies
module rrm_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_d [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_d[i] <= r_d[i-1];
            end
        end
    end

    assign o_d = r_d[N-1];

endmodule

### design/rrm_horner_step.sv
// one series term: t = one - min(one, round(x2 * t / k)), five register stages
// depends on rrm_pkg and rrm_delay
module rrm_horner_step #(
    parameter int unsigned K = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_t,
    output logic [31:0] o_x2,
    output logic [30:0] o_t
);
    import rrm_pkg::*;

    // reciprocal scaled by 2^40, rounded up, exact for 32-bit dividends
    localparam logic [63:0] RECIP = ((64'd1 << 40) + 64'(K) - 64'd1) / 64'(K);
    localparam logic [63:0] BIAS = 64'(K) << (QB - 1);

    logic [62:0] r_p;
    logic [31:0] r_y;
    logic [51:0] r_pl;
    logic [51:0] r_ph;
    logic [31:0] r_q;
    logic [30:0] r_t;
    logic [63:0] n_sum;
    logic [71:0] n_acc;

    always_comb begin
        n_sum = 64'(r_p) + BIAS;
        n_acc = (72'(r_ph) << 20) + 72'(r_pl);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= 63'(i_x2) * 63'(i_t);
            r_y  <= n_sum[61:30];
            r_pl <= 52'(r_y) * 52'(RECIP[19:0]);
            r_ph <= 52'(r_y) * 52'(RECIP[39:20]);
            r_q  <= n_acc[71:40];
            r_t  <= (r_q >= 32'(ONE_Q)) ? 31'd0 : 31'(32'(ONE_Q) - r_q);
        end
    end

    rrm_delay #(.W(32), .N(STEP_LAT)) u_x2_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_x2), .o_d(o_x2)
    );

    assign o_t = r_t;

endmodule

### design/rrm_sincos.sv
// pipelined sine and cosine of a turn fraction by quadrant folding and series
// depends on rrm_pkg, rrm_delay and rrm_horner_step
module rrm_sincos #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_turns,
    output rrm_pkg::t_q          o_sin,
    output rrm_pkg::t_q          o_cos
);
    import rrm_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [29:0] n_t;
    logic [60:0] r_tp;
    logic [30:0] r_x;
    logic [61:0] r_xx;
    logic [31:0] r_x2;
    logic [61:0] r_sp;
    logic [30:0] r_s0;
    logic [30:0] w_x_d;
    logic [30:0] w_s0_d;
    logic [1:0]  w_q_d;
    logic [61:0] n_x_sum;
    logic [61:0] n_x2_sum;
    logic [61:0] n_s_sum;
    t_q          n_s0;
    t_q          n_c0;
    t_q          r_sin;
    t_q          r_cos;

    logic [31:0] w_sx2 [N_SIN+1];
    logic [30:0] w_st  [N_SIN+1];
    logic [31:0] w_cx2 [N_COS+1];
    logic [30:0] w_ct  [N_COS+1];

    // position inside the quadrant as Q0.30 of a quarter turn
    assign n_t = 30'(i_turns[FRAC_BITS-3:0]) << (32 - FRAC_BITS);

    always_comb begin
        n_x_sum  = 62'(r_tp) + RND_Q;
        n_x2_sum = r_xx + RND_Q;
        n_s_sum  = r_sp + RND_Q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tp <= 61'(n_t) * 61'(HALF_PI_Q);
            r_x  <= n_x_sum[60:30];
            r_xx <= 62'(r_x) * 62'(r_x);
            r_x2 <= n_x2_sum[61:30];
            r_sp <= 62'(w_x_d) * 62'(w_st[N_SIN]);
            r_s0 <= n_s_sum[60:30];
        end
    end

    assign w_sx2[0] = r_x2;
    assign w_st[0]  = ONE_Q;
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = ONE_Q;

    for (genvar i = 0; i < N_SIN; i++) begin : g_sin
        rrm_horner_step #(.K(SIN_DIV[i])) u_step (
            .i_clk(i_clk), .i_en(i_en),
            .i_x2(w_sx2[i]), .i_t(w_st[i]),
            .o_x2(w_sx2[i+1]), .o_t(w_st[i+1])
        );
    end

    for (genvar i = 0; i < N_COS; i++) begin : g_cos
        rrm_horner_step #(.K(COS_DIV[i])) u_step (
            .i_clk(i_clk), .i_en(i_en),
            .i_x2(w_cx2[i]), .i_t(w_ct[i]),
            .o_x2(w_cx2[i+1]), .o_t(w_ct[i+1])
        );
    end

    // x waits for the squaring stages and the sine series
    rrm_delay #(.W(31), .N(N_SIN * STEP_LAT + 2)) u_x_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_x), .o_d(w_x_d)
    );

    // sine finishes ahead of the longer cosine series
    rrm_delay #(.W(31), .N((N_COS - N_SIN) * STEP_LAT - 2)) u_s0_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_s0), .o_d(w_s0_d)
    );

    rrm_delay #(.W(2), .N(SC_LAT - 1)) u_q_dly (
        .i_clk(i_clk), .i_en(i_en),
        .i_d(i_turns[FRAC_BITS-1:FRAC_BITS-2]), .o_d(w_q_d)
    );

    always_comb begin
        n_s0 = t_q'({3'b000, w_s0_d});
        n_c0 = t_q'({3'b000, w_ct[N_COS]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (w_q_d)
                QUAD_0: begin r_sin <= n_s0;  r_cos <= n_c0;  end
                QUAD_1: begin r_sin <= n_c0;  r_cos <= -n_s0; end
                QUAD_2: begin r_sin <= -n_s0; r_cos <= -n_c0; end
                QUAD_3: begin r_sin <= -n_c0; r_cos <= n_s0;  end
                default: begin r_sin <= n_s0; r_cos <= n_c0;  end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### design/rrm_isqrt.sv
// pipelined floor square root of a 62-bit value, one result bit per stage
// depends on rrm_pkg
module rrm_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_v,
    output logic [30:0] o_root
);
    import rrm_pkg::*;

    logic [32:0] r_rem  [SQ_LAT];
    logic [30:0] r_root [SQ_LAT];
    logic [61:0] r_v    [SQ_LAT-1];
    logic [32:0] n_rem  [SQ_LAT];
    logic [30:0] n_root [SQ_LAT];
    logic [61:0] n_v    [SQ_LAT-1];

    always_comb begin
        logic [32:0] p_rem;
        logic [30:0] p_root;
        logic [61:0] p_v;
        logic [34:0] trial;
        logic [34:0] test;
        for (int s = 0; s < SQ_LAT; s++) begin
            if (s == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_v    = i_v;
            end else begin
                p_rem  = r_rem[s-1];
                p_root = r_root[s-1];
                p_v    = r_v[s-1];
            end
            // bring down the next two bits and try the next root bit
            trial = {p_rem, p_v[61:60]};
            test  = {2'b00, p_root, 2'b01};
            if (trial >= test) begin
                n_rem[s]  = 33'(trial - test);
                n_root[s] = {p_root[29:0], 1'b1};
            end else begin
                n_rem[s]  = trial[32:0];
                n_root[s] = {p_root[29:0], 1'b0};
            end
            if (s < SQ_LAT - 1) begin
                n_v[s] = {p_v[59:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_v    <= n_v;
        end
    end

    assign o_root = r_root[SQ_LAT-1];

endmodule

### design/random_rotation_matrix_3d.sv
// top level: uniform random 3x3 rotation matrix from three fractions
// depends on rrm_pkg, rrm_delay, rrm_sincos, rrm_isqrt and assert_macros.svh
//
// One transaction per clock is sustained while i_ready stays high. The depth
// comes from the seven-term cosine series (five stages per term) followed by
// the reflection products and the output rounding. Two slots at the output let
// the pipeline keep moving when i_ready drops, until the second slot fills;
// o_ready is low only while that second slot is occupied. No state is kept
// between transactions.
`include "assert_macros.svh"

module random_rotation_matrix_3d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [FRAC_BITS:0]          i_spin_turns,
    input  logic [FRAC_BITS:0]          i_pole_direction_turns,
    input  logic [FRAC_BITS:0]          i_pole_deflection,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [FRAC_BITS+1:0] o_m00,
    output logic signed [FRAC_BITS+1:0] o_m01,
    output logic signed [FRAC_BITS+1:0] o_m02,
    output logic signed [FRAC_BITS+1:0] o_m10,
    output logic signed [FRAC_BITS+1:0] o_m11,
    output logic signed [FRAC_BITS+1:0] o_m12,
    output logic signed [FRAC_BITS+1:0] o_m20,
    output logic signed [FRAC_BITS+1:0] o_m21,
    output logic signed [FRAC_BITS+1:0] o_m22
);
    import rrm_pkg::*;

    typedef logic signed [FRAC_BITS+1:0] t_ent;

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0] OUT_H = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
    localparam logic signed [35:0] OUT_LIM = 36'sd1 <<< FRAC_BITS;
    localparam t_ent ENT_MAX = {2'b01, {FRAC_BITS{1'b0}}};
    localparam t_ent ENT_MIN = -ENT_MAX;

    // Q.30 entry to output format, half away from zero, then clamp to [-1,1]
    function automatic t_ent f_to_out(input t_q v);
        logic signed [35:0] w;
        logic signed [35:0] rr;
        w  = 36'(v);
        rr = (w + OUT_H - (((SH > 0) && (v < 0)) ? 36'sd1 : 36'sd0)) >>> SH;
        if (rr > OUT_LIM) begin
            rr = OUT_LIM;
        end else if (rr < -OUT_LIM) begin
            rr = -OUT_LIM;
        end
        return t_ent'(rr[FRAC_BITS+1:0]);
    endfunction

    logic              en;
    logic              push;
    logic [P_LAT-1:0]  r_vld;
    logic              r_ov;
    logic              r_sv;

    // deflection side, entry stage
    logic [FRAC_BITS:0] n_dsat;
    logic [31:0]        n_z;
    logic [61:0]        n_vr;
    logic [61:0]        n_vz;
    t_q                 n_omz;

    t_q          w_st, w_ct, w_sp, w_cp;
    logic [30:0] w_r, w_vz_root;
    logic [30:0] w_r40, w_vz45;
    t_q          w_ct42, w_st42, w_ct47, w_st47, w_omz47;
    t_q          w_vx45, w_vy45;
    t_q          n_r40, n_vz45;

    t_prod r_pvx, r_pvy;
    t_q    r_vx, r_vy;
    t_prod r_pxc, r_pys, r_pxs, r_pyc;
    t_q    r_xc, r_ys, r_xs, r_yc;
    t_q    r_sx, r_sy;
    t_prod r_pp [8];
    t_q    r_pr [8];
    t_q    r_e  [9];
    t_ent  r_m  [9];
    t_ent  r_od [9];
    t_ent  r_sd [9];

    always_comb begin
        n_dsat = (i_pole_deflection > (FRAC_BITS+1)'(1) << FRAC_BITS)
               ? ((FRAC_BITS+1)'(1) << FRAC_BITS) : i_pole_deflection;
        n_z    = 32'(n_dsat) << (31 - FRAC_BITS);
        n_vr   = 62'(n_z) << QB;
        n_vz   = 62'(32'h8000_0000 - n_z) << QB;
        n_omz  = t_q'(ONE_Q) - t_q'({2'b00, n_z});
    end

    rrm_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_theta (
        .i_clk(i_clk), .i_en(en), .i_turns(i_spin_turns[FRAC_BITS-1:0]),
        .o_sin(w_st), .o_cos(w_ct)
    );

    rrm_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_phi (
        .i_clk(i_clk), .i_en(en), .i_turns(i_pole_direction_turns[FRAC_BITS-1:0]),
        .o_sin(w_sp), .o_cos(w_cp)
    );

    rrm_isqrt u_sqrt_r (
        .i_clk(i_clk), .i_en(en), .i_v(n_vr), .o_root(w_r)
    );

    rrm_isqrt u_sqrt_vz (
        .i_clk(i_clk), .i_en(en), .i_v(n_vz), .o_root(w_vz_root)
    );

    rrm_delay #(.W(31), .N(SC_LAT - SQ_LAT)) u_r_dly (
        .i_clk(i_clk), .i_en(en), .i_d(w_r), .o_d(w_r40)
    );

    rrm_delay #(.W(31), .N(SC_LAT - SQ_LAT + 5)) u_vz_dly (
        .i_clk(i_clk), .i_en(en), .i_d(w_vz_root), .o_d(w_vz45)
    );

    rrm_delay #(.W(34), .N(2)) u_ct42 (
        .i_clk(i_clk), .i_en(en), .i_d(w_ct), .o_d(w_ct42)
    );

    rrm_delay #(.W(34), .N(2)) u_st42 (
        .i_clk(i_clk), .i_en(en), .i_d(w_st), .o_d(w_st42)
    );

    rrm_delay #(.W(34), .N(5)) u_ct47 (
        .i_clk(i_clk), .i_en(en), .i_d(w_ct42), .o_d(w_ct47)
    );

    rrm_delay #(.W(34), .N(5)) u_st47 (
        .i_clk(i_clk), .i_en(en), .i_d(w_st42), .o_d(w_st47)
    );

    rrm_delay #(.W(34), .N(3)) u_vx45 (
        .i_clk(i_clk), .i_en(en), .i_d(r_vx), .o_d(w_vx45)
    );

    rrm_delay #(.W(34), .N(3)) u_vy45 (
        .i_clk(i_clk), .i_en(en), .i_d(r_vy), .o_d(w_vy45)
    );

    rrm_delay #(.W(34), .N(P_LAT - 2)) u_omz_dly (
        .i_clk(i_clk), .i_en(en), .i_d(n_omz), .o_d(w_omz47)
    );

    always_comb begin
        n_r40  = t_q'({3'b000, w_r40});
        n_vz45 = t_q'({3'b000, w_vz45});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // reflection vector x and y
            r_pvx <= t_prod'(w_sp) * t_prod'(n_r40);
            r_pvy <= t_prod'(w_cp) * t_prod'(n_r40);
            r_vx  <= f_rnd_q30(r_pvx);
            r_vy  <= f_rnd_q30(r_pvy);
            // s = v^T * rotation
            r_pxc <= t_prod'(r_vx) * t_prod'(w_ct42);
            r_pys <= t_prod'(r_vy) * t_prod'(w_st42);
            r_pxs <= t_prod'(r_vx) * t_prod'(w_st42);
            r_pyc <= t_prod'(r_vy) * t_prod'(w_ct42);
            r_xc  <= f_rnd_q30(r_pxc);
            r_ys  <= f_rnd_q30(r_pys);
            r_xs  <= f_rnd_q30(r_pxs);
            r_yc  <= f_rnd_q30(r_pyc);
            r_sx  <= r_xc - r_ys;
            r_sy  <= r_xs + r_yc;
            // outer product v * s
            r_pp[0] <= t_prod'(w_vx45) * t_prod'(r_sx);
            r_pp[1] <= t_prod'(w_vx45) * t_prod'(r_sy);
            r_pp[2] <= t_prod'(w_vx45) * t_prod'(n_vz45);
            r_pp[3] <= t_prod'(w_vy45) * t_prod'(r_sx);
            r_pp[4] <= t_prod'(w_vy45) * t_prod'(r_sy);
            r_pp[5] <= t_prod'(w_vy45) * t_prod'(n_vz45);
            r_pp[6] <= t_prod'(n_vz45) * t_prod'(r_sx);
            r_pp[7] <= t_prod'(n_vz45) * t_prod'(r_sy);
            for (int i = 0; i < 8; i++) begin
                r_pr[i] <= f_rnd_q30(r_pp[i]);
            end
            r_e[0] <= r_pr[0] - w_ct47;
            r_e[1] <= r_pr[1] - w_st47;
            r_e[2] <= r_pr[2];
            r_e[3] <= r_pr[3] + w_st47;
            r_e[4] <= r_pr[4] - w_ct47;
            r_e[5] <= r_pr[5];
            r_e[6] <= r_pr[6];
            r_e[7] <= r_pr[7];
            r_e[8] <= w_omz47;
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= f_to_out(r_e[i]);
            end
        end
    end

    // pipeline advances unless the second output slot is occupied
    assign en      = !r_sv;
    assign o_ready = en;
    assign push    = en && r_vld[P_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[P_LAT-2:0], i_valid};
            end
            if (!r_ov || i_ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= push;
                end
            end else if (push) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_od <= r_sd;
            end else if (push) begin
                r_od <= r_m;
            end
        end else if (push) begin
            r_sd <= r_m;
        end
    end

    assign o_valid = r_ov;
    assign o_m00 = r_od[0];
    assign o_m01 = r_od[1];
    assign o_m02 = r_od[2];
    assign o_m10 = r_od[3];
    assign o_m11 = r_od[4];
    assign o_m12 = r_od[5];
    assign o_m20 = r_od[6];
    assign o_m21 = r_od[7];
    assign o_m22 = r_od[8];

    `ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_sv && !r_ov, "second slot full while output slot empty")
    `ASSERT_PROP(a_stall_fills_skid, i_clk, i_rst_n, (r_ov && !i_ready && push) |=> r_sv, "stalled transaction not kept in second slot")
    `ASSERT_PROP(a_accept_enters, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0], "accepted transaction missing from first stage")
    `ASSERT_PROP(a_m22_range, i_clk, i_rst_n, o_valid |-> (o_m22 <= ENT_MAX && o_m22 >= ENT_MIN), "m22 outside [-1,1]")

endmodule
